@@ rtl/tli_pkg.sv @@
package tli_pkg;

  localparam int unsigned TableDepth = 1024;
  localparam int unsigned IdxW       = $clog2(TableDepth);
  localparam int unsigned CountW     = 11;
  localparam int unsigned DataW      = 32;
  localparam int unsigned FracBits   = 16;
  localparam int unsigned DiffW      = DataW + 1;
  localparam int unsigned StepW      = $clog2(FracBits + 1);

  localparam logic OpWrite = 1'b0;
  localparam logic OpQuery = 1'b1;

  typedef struct packed {
    logic signed [DataW-1:0] radius;
    logic signed [DataW-1:0] value;
    logic signed [DataW-1:0] slope;
  } entry_t;

  typedef struct packed {
    logic             start;
    logic [DiffW-1:0] num;
    logic [DiffW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                done;
    logic [FracBits-1:0] quot;
  } div_rsp_t;

endpackage

@@ rtl/table_linear_interpolator.sv @@
// A write transaction stores one table entry and leaves busy low.
// A query transaction raises busy and returns one result strobed by valid_o for
// exactly one cycle; the receiver cannot stall it, so capture the result when valid_o
// is high. The end checks clamp a query to the first or to the last entry; an
// interior query then runs the binary search steps on the single table memory port,
// the bracketing reads, the bit-serial fraction divider and the multiply and output
// steps.
module table_linear_interpolator (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic                                opcode_i,
  input  logic [tli_pkg::IdxW-1:0]            entry_index_i,
  input  logic signed [tli_pkg::DataW-1:0]    radius_i,
  input  logic signed [tli_pkg::DataW-1:0]    sample_value_i,
  input  logic signed [tli_pkg::DataW-1:0]    sample_slope_i,
  input  logic                                point_count_we_i,
  input  logic [tli_pkg::CountW-1:0]          point_count_wdata_i,
  output logic                                valid_o,
  output logic signed [tli_pkg::DataW-1:0]    value_out_o,
  output logic signed [tli_pkg::DataW-1:0]    slope_out_o
);

  typedef enum logic [11:0] {
    StIdle = 12'b000000000001,
    StRd0  = 12'b000000000010,
    StCk0  = 12'b000000000100,
    StCkL  = 12'b000000001000,
    StSReq = 12'b000000010000,
    StSCmp = 12'b000000100000,
    StRdLo = 12'b000001000000,
    StRdHi = 12'b000010000000,
    StPrep = 12'b000100000000,
    StDiv  = 12'b001000000000,
    StMul  = 12'b010000000000,
    StOut  = 12'b100000000000
  } state_e;

  state_e state_q, state_d;

  logic [tli_pkg::CountW-1:0]       pc_q;
  logic [tli_pkg::IdxW-1:0]         last;
  logic [tli_pkg::IdxW-1:0]         lo_q, lo_d, hi_q, hi_d, mid;
  logic [tli_pkg::IdxW:0]           lohi_sum;
  logic signed [tli_pkg::DataW-1:0] r_q, r_d;
  tli_pkg::entry_t                  elo_q, elo_d, ehi_q, ehi_d;
  logic [tli_pkg::FracBits-1:0]     t_q, t_d;
  logic                             vld_q, vld_d;
  logic signed [tli_pkg::DataW-1:0] vo_q, vo_d, so_q, so_d;
  logic                             ram_we, lerp_load;
  logic [tli_pkg::IdxW-1:0]         ram_addr;
  tli_pkg::entry_t                  wentry, rentry;
  tli_pkg::div_req_t                dreq;
  tli_pkg::div_rsp_t                drsp;
  logic signed [tli_pkg::DataW-1:0] lv, ls;

  always_comb begin
    if (pc_q == '0) begin
      last = '0;
    end else if (pc_q > tli_pkg::CountW'(tli_pkg::TableDepth)) begin
      last = tli_pkg::IdxW'(tli_pkg::TableDepth - 1);
    end else begin
      last = tli_pkg::IdxW'(pc_q - 1'b1);
    end
  end

  assign lohi_sum = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid      = lohi_sum[tli_pkg::IdxW:1];

  assign wentry.radius = radius_i;
  assign wentry.value  = sample_value_i;
  assign wentry.slope  = sample_slope_i;

  always_comb begin
    state_d   = state_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    r_d       = r_q;
    elo_d     = elo_q;
    ehi_d     = ehi_q;
    t_d       = t_q;
    vld_d     = 1'b0;
    vo_d      = vo_q;
    so_d      = so_q;
    ram_we    = 1'b0;
    ram_addr  = '0;
    lerp_load = 1'b0;
    dreq.start = 1'b0;
    dreq.num   = tli_pkg::DiffW'($signed({r_q[tli_pkg::DataW-1], r_q})
                 - $signed({elo_q.radius[tli_pkg::DataW-1], elo_q.radius}));
    dreq.den   = tli_pkg::DiffW'($signed({rentry.radius[tli_pkg::DataW-1], rentry.radius})
                 - $signed({elo_q.radius[tli_pkg::DataW-1], elo_q.radius}));
    case (state_q)
      StIdle: begin
        if (start) begin
          if (opcode_i == tli_pkg::OpWrite) begin
            ram_we   = 1'b1;
            ram_addr = entry_index_i;
          end else begin
            r_d     = radius_i;
            state_d = StRd0;
          end
        end
      end
      StRd0: begin
        ram_addr = '0;
        state_d  = StCk0;
      end
      StCk0: begin
        if (r_q <= rentry.radius) begin
          vo_d    = rentry.value;
          so_d    = rentry.slope;
          vld_d   = 1'b1;
          state_d = StIdle;
        end else begin
          ram_addr = last;
          state_d  = StCkL;
        end
      end
      StCkL: begin
        if (r_q >= rentry.radius) begin
          vo_d    = rentry.value;
          so_d    = rentry.slope;
          vld_d   = 1'b1;
          state_d = StIdle;
        end else begin
          lo_d    = '0;
          hi_d    = last;
          state_d = (last > tli_pkg::IdxW'(1)) ? StSReq : StRdLo;
        end
      end
      StSReq: begin
        ram_addr = mid;
        state_d  = StSCmp;
      end
      StSCmp: begin
        if (rentry.radius <= r_q) begin
          lo_d = mid;
        end else begin
          hi_d = mid;
        end
        state_d = (hi_d - lo_d > tli_pkg::IdxW'(1)) ? StSReq : StRdLo;
      end
      StRdLo: begin
        ram_addr = lo_q;
        state_d  = StRdHi;
      end
      StRdHi: begin
        ram_addr = hi_q;
        elo_d    = rentry;
        state_d  = StPrep;
      end
      StPrep: begin
        ehi_d = rentry;
        if (rentry.radius > elo_q.radius && r_q >= elo_q.radius) begin
          dreq.start = 1'b1;
          state_d    = StDiv;
        end else begin
          t_d     = '0;
          state_d = StMul;
        end
      end
      StDiv: begin
        if (drsp.done) begin
          t_d     = drsp.quot;
          state_d = StMul;
        end
      end
      StMul: begin
        lerp_load = 1'b1;
        state_d   = StOut;
      end
      StOut: begin
        vo_d    = lv;
        so_d    = ls;
        vld_d   = 1'b1;
        state_d = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      vld_q   <= 1'b0;
      pc_q    <= tli_pkg::CountW'(1);
    end else begin
      state_q <= state_d;
      vld_q   <= vld_d;
      if (point_count_we_i) begin
        pc_q <= point_count_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q  <= lo_d;
    hi_q  <= hi_d;
    r_q   <= r_d;
    elo_q <= elo_d;
    ehi_q <= ehi_d;
    t_q   <= t_d;
    vo_q  <= vo_d;
    so_q  <= so_d;
  end

  tli_ram #(
    .AddrW (tli_pkg::IdxW),
    .Width ($bits(tli_pkg::entry_t))
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (wentry),
    .rdata_o (rentry)
  );

  tli_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (dreq),
    .rsp_o  (drsp)
  );

  tli_lerp u_lerp_value (
    .clk_i  (clk_i),
    .load_i (lerp_load),
    .a_i    (elo_q.value),
    .b_i    (ehi_q.value),
    .t_i    (t_q),
    .res_o  (lv)
  );

  tli_lerp u_lerp_slope (
    .clk_i  (clk_i),
    .load_i (lerp_load),
    .a_i    (elo_q.slope),
    .b_i    (ehi_q.slope),
    .t_i    (t_q),
    .res_o  (ls)
  );

  assign busy        = (state_q != StIdle);
  assign valid_o     = vld_q;
  assign value_out_o = vo_q;
  assign slope_out_o = so_q;

endmodule

@@ rtl/tli_ram.sv @@
module tli_ram #(
  parameter int unsigned AddrW = 10,
  parameter int unsigned Width = 96
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [Width-1:0] wdata_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [2**AddrW];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end else begin
      rdata_o <= mem[addr_i];
    end
  end

endmodule

@@ rtl/tli_div.sv @@
module tli_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tli_pkg::div_req_t  req_i,
  output tli_pkg::div_rsp_t  rsp_o
);

  logic [tli_pkg::DiffW:0]      rem_q, rem_d, sh;
  logic [tli_pkg::DiffW-1:0]    den_q, den_d;
  logic [tli_pkg::FracBits-1:0] quo_q, quo_d;
  logic [tli_pkg::StepW-1:0]    cnt_q, cnt_d;
  logic                         run_q, run_d, done_q, done_d;

  always_comb begin
    sh     = {rem_q[tli_pkg::DiffW-1:0], 1'b0};
    rem_d  = rem_q;
    den_d  = den_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (req_i.start) begin
      rem_d = {1'b0, req_i.num};
      den_d = req_i.den;
      cnt_d = '0;
      run_d = 1'b1;
    end else if (run_q) begin
      if (sh >= {1'b0, den_q}) begin
        rem_d = sh - {1'b0, den_q};
        quo_d = {quo_q[tli_pkg::FracBits-2:0], 1'b1};
      end else begin
        rem_d = sh;
        quo_d = {quo_q[tli_pkg::FracBits-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == tli_pkg::StepW'(tli_pkg::FracBits - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    quo_q <= quo_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;

endmodule

@@ rtl/tli_lerp.sv @@
module tli_lerp (
  input  logic                              clk_i,
  input  logic                              load_i,
  input  logic signed [tli_pkg::DataW-1:0]  a_i,
  input  logic signed [tli_pkg::DataW-1:0]  b_i,
  input  logic [tli_pkg::FracBits-1:0]      t_i,
  output logic signed [tli_pkg::DataW-1:0]  res_o
);

  localparam int unsigned ProdW = tli_pkg::DiffW + tli_pkg::FracBits;
  localparam int unsigned SumW  = tli_pkg::DataW + 2;

  logic signed [tli_pkg::DiffW-1:0] d;
  logic [tli_pkg::DiffW-1:0]        mag;
  logic [ProdW-1:0]                 p_q;
  logic                             neg_q;
  logic signed [tli_pkg::DataW-1:0] a_q;
  logic [ProdW:0]                   rnd;
  logic signed [SumW-1:0]           m, s;

  assign d   = {b_i[tli_pkg::DataW-1], b_i} - {a_i[tli_pkg::DataW-1], a_i};
  assign mag = d[tli_pkg::DiffW-1] ? tli_pkg::DiffW'(-d) : tli_pkg::DiffW'(d);

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      p_q   <= ProdW'(mag * t_i);
      neg_q <= d[tli_pkg::DiffW-1];
      a_q   <= a_i;
    end
  end

  always_comb begin
    if (neg_q) begin
      rnd = {1'b0, p_q} + (ProdW+1)'((1 << tli_pkg::FracBits) - 1);
      m   = -$signed(SumW'(rnd >> tli_pkg::FracBits));
    end else begin
      rnd = {1'b0, p_q};
      m   = $signed(SumW'(rnd >> tli_pkg::FracBits));
    end
    s = {{2{a_q[tli_pkg::DataW-1]}}, a_q} + m;
    if (s > $signed({2'b00, 1'b0, {(tli_pkg::DataW-1){1'b1}}})) begin
      res_o = {1'b0, {(tli_pkg::DataW-1){1'b1}}};
    end else if (s < $signed({2'b11, 1'b1, {(tli_pkg::DataW-1){1'b0}}})) begin
      res_o = {1'b1, {(tli_pkg::DataW-1){1'b0}}};
    end else begin
      res_o = s[tli_pkg::DataW-1:0];
    end
  end

endmodule
